>>> rtl/core/gbba_pkg.sv
// Shared constants and types for the group bitmap block allocator.
package gbba_pkg;

   localparam int DEF_MAX_GROUPS       = 8;
   localparam int DEF_MAX_GROUP_BLOCKS = 1024;

   localparam int BLK_W      = 14;
   localparam int BPG_W      = 11;
   localparam int ACTION_W   = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int WORD_W     = 64;

   localparam int GROUP_CNT_MAX = 2047;
   localparam int TOTAL_CNT_MAX = 16383;

   localparam logic [BPG_W-1:0] RST_BLOCKS_PER_GROUP = 11'd1024;
   localparam logic [BLK_W-1:0] RST_TOTAL_BLOCKS     = 14'd8192;
   localparam logic             RST_FIRST_DATA_BLOCK = 1'b0;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS_PER_GROUP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_BLOCKS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DATA_BLOCK = 2'd2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_MARK  = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK      = 2'd0,
      STS_NO_FREE = 2'd1,
      STS_ZERO    = 2'd2,
      STS_RANGE   = 2'd3
   } status_type;

endpackage

>>> rtl/core/group_bitmap_block_allocator.sv
// Top level of the group bitmap block allocator with its bitmap memory and sequencer.
//
// The block hands out and takes back blocks through a usage bitmap kept in a 64-bit wide,
// single-port memory, one word read or written per cycle, with per-group free counters and
// a total free counter in registers. One item is worked on at a time and every item gives
// exactly one result. An allocate looks at the groups in order, skips a group on a zero
// counter, and reads and tests each bitmap word of a group with a nonzero counter until it
// finds a first fit or reaches the group's end, so a full group whose counter is still
// nonzero has all its words read and tested. Free and mark-used step through the
// block-to-group mapping, then read and test the one word that holds the block; clear-all,
// a free of block zero and a block out of range go from decode straight to the result. A
// per-word valid vector makes reset and clear-all take effect at once. After reset and after
// every configuration write the input stalls while the group count is worked out by
// repeated addition. A finished result waits in an output register while the next item is
// taken.
module group_bitmap_block_allocator #(
   parameter int MAX_GROUPS       = gbba_pkg::DEF_MAX_GROUPS,
   parameter int MAX_GROUP_BLOCKS = gbba_pkg::DEF_MAX_GROUP_BLOCKS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [gbba_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gbba_pkg::BLK_W-1:0]       csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [gbba_pkg::ACTION_W-1:0]    req_action,
   input  logic [gbba_pkg::BLK_W-1:0]       req_block_number,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [gbba_pkg::BLK_W-1:0]       rsp_allocated_block,
   output logic [gbba_pkg::STATUS_W-1:0]    rsp_status,
   output logic [gbba_pkg::BLK_W-1:0]       rsp_free_total
);
   import gbba_pkg::*;

   localparam int NUM_WORDS = (MAX_GROUPS * MAX_GROUP_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int POS_W     = WA_W + 6;
   localparam int PB_W      = POS_W + 1;
   localparam int GI_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int GC_W      = $clog2(MAX_GROUPS + 1);
   localparam int SPAN_W    = $clog2(MAX_GROUPS * GROUP_CNT_MAX + 1);
   localparam int SUM_W     = SPAN_W + 1;
   localparam int CMP_W     = (SPAN_W > BLK_W) ? SPAN_W : BLK_W;

   localparam logic [BPG_W-1:0] BPG_CLAMP = (MAX_GROUP_BLOCKS > GROUP_CNT_MAX) ?
                                            BPG_W'(GROUP_CNT_MAX) : BPG_W'(MAX_GROUP_BLOCKS);
   localparam logic [PB_W-1:0]  GRP_STRIDE = PB_W'(MAX_GROUP_BLOCKS);
   localparam logic [GC_W-1:0]  GRP_LIMIT  = GC_W'(MAX_GROUPS);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECODE = 7'b0000010,
      ST_DIV    = 7'b0000100,
      ST_GSEL   = 7'b0001000,
      ST_READ   = 7'b0010000,
      ST_TEST   = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type                 state_ff, state_in;

   logic [BPG_W-1:0]          bpg_ff, bpg_in;
   logic [BLK_W-1:0]          tblk_ff, tblk_in;
   logic                      fdb_ff, fdb_in;

   logic                      geo_busy_ff, geo_busy_in;
   logic [GC_W-1:0]           groups_ff, groups_in;
   logic [SPAN_W-1:0]         span_ff, span_in;

   action_type                act_ff, act_in;
   logic [BLK_W-1:0]          blk_ff, blk_in;
   logic [BLK_W-1:0]          rem_ff, rem_in;
   logic [GC_W-1:0]           g_ff, g_in;
   logic [PB_W-1:0]           grp_base_ff, grp_base_in;
   logic [SPAN_W-1:0]         grp_off_ff, grp_off_in;
   logic [WA_W-1:0]           w_ff, w_in;
   logic [5:0]                bit_ff, bit_in;

   logic [BPG_W-1:0]          grp_cnt_ff [MAX_GROUPS];
   logic [BPG_W-1:0]          grp_cnt_in [MAX_GROUPS];
   logic [BLK_W-1:0]          total_ff, total_in;

   logic [NUM_WORDS-1:0]      word_vld_ff, word_vld_in;
   logic [WORD_W-1:0]         bitmap_mem [NUM_WORDS];
   logic [WORD_W-1:0]         rd_word_ff;
   logic                      rd_vld_ff;
   logic                      mem_we;
   logic [WORD_W-1:0]         mem_wdata;

   logic [BLK_W-1:0]          res_blk_ff, res_blk_in;
   status_type                res_sts_ff, res_sts_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [BLK_W-1:0]          rsp_blk_ff, rsp_blk_in;
   status_type                rsp_sts_ff, rsp_sts_in;
   logic [BLK_W-1:0]          rsp_tot_ff, rsp_tot_in;

   logic [BPG_W-1:0]          bpg_eff;
   logic                      req_xfer;

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || geo_busy_ff;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_allocated_block = rsp_blk_ff;
   assign rsp_status          = rsp_sts_ff;
   assign rsp_free_total      = rsp_tot_ff;

   assign bpg_eff = (bpg_ff == '0) ? BPG_W'(1) : ((bpg_ff > BPG_CLAMP) ? BPG_CLAMP : bpg_ff);

   // Configuration registers and the group count, found by adding the group size until
   // the block count is covered or MAX_GROUPS groups are counted.
   always_comb begin
      bpg_in      = bpg_ff;
      tblk_in     = tblk_ff;
      fdb_in      = fdb_ff;
      geo_busy_in = geo_busy_ff;
      groups_in   = groups_ff;
      span_in     = span_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BLOCKS_PER_GROUP: bpg_in  = csr_wdata[BPG_W-1:0];
            CSR_TOTAL_BLOCKS:     tblk_in = csr_wdata;
            CSR_FIRST_DATA_BLOCK: fdb_in  = csr_wdata[0];
            default: ;
         endcase
         geo_busy_in = 1'b1;
         groups_in   = '0;
         span_in     = '0;
      end else if (geo_busy_ff) begin
         if ((groups_ff < GRP_LIMIT) && (CMP_W'(span_ff) < CMP_W'(tblk_ff))) begin
            groups_in = groups_ff + GC_W'(1);
            span_in   = span_ff + SPAN_W'(bpg_eff);
         end else begin
            geo_busy_in = 1'b0;
         end
      end
   end

   // Item sequencer.
   always_comb begin
      logic [BPG_W-1:0]  cnt_sel;
      logic [PB_W-1:0]   word_base;
      logic [PB_W-1:0]   grp_end;
      logic [PB_W-1:0]   hi_span;
      logic [6:0]        hi_cnt;
      logic [5:0]        lo_cnt;
      logic [WORD_W-1:0] rd_data;
      logic [WORD_W-1:0] free_vec;
      logic [5:0]        first_j;
      logic              end_here;
      logic [PB_W-1:0]   off_in_grp;
      logic [SUM_W-1:0]  alloc_sum;
      logic [BLK_W-1:0]  rel;
      logic [PB_W-1:0]   pos;

      state_in    = state_ff;
      act_in      = act_ff;
      blk_in      = blk_ff;
      rem_in      = rem_ff;
      g_in        = g_ff;
      grp_base_in = grp_base_ff;
      grp_off_in  = grp_off_ff;
      w_in        = w_ff;
      bit_in      = bit_ff;
      grp_cnt_in  = grp_cnt_ff;
      total_in    = total_ff;
      word_vld_in = word_vld_ff;
      res_blk_in  = res_blk_ff;
      res_sts_in  = res_sts_ff;
      mem_we      = 1'b0;
      mem_wdata   = '0;

      cnt_sel   = grp_cnt_ff[g_ff[GI_W-1:0]];
      word_base = {1'b0, w_ff, 6'd0};
      grp_end   = grp_base_ff + PB_W'(bpg_eff);
      hi_span   = grp_end - word_base;
      end_here  = (grp_end <= word_base + PB_W'(WORD_W));
      hi_cnt    = end_here ? hi_span[6:0] : 7'd64;
      lo_cnt    = (grp_base_ff[PB_W-1:6] == {1'b0, w_ff}) ? grp_base_ff[5:0] : 6'd0;
      rd_data   = rd_vld_ff ? rd_word_ff : '0;
      free_vec  = ~rd_data & ({WORD_W{1'b1}} << lo_cnt)
                  & ({WORD_W{1'b1}} >> (7'd64 - hi_cnt));
      first_j   = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (free_vec[j]) begin
            first_j = 6'(j);
         end
      end
      off_in_grp = {1'b0, w_ff, first_j} - grp_base_ff;
      alloc_sum  = SUM_W'(grp_off_ff) + SUM_W'(off_in_grp) + SUM_W'(fdb_ff);
      rel        = blk_ff - BLK_W'(fdb_ff);
      pos        = grp_base_ff + PB_W'(rem_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               act_in   = action_type'(req_action);
               blk_in   = req_block_number;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            res_blk_in  = '0;
            res_sts_in  = STS_OK;
            g_in        = '0;
            grp_base_in = '0;
            grp_off_in  = '0;
            rem_in      = rel;
            unique case (act_ff) inside
               ACT_ALLOC: state_in = ST_GSEL;
               ACT_CLEAR: begin
                  word_vld_in = '0;
                  for (int i = 0; i < MAX_GROUPS; i++) begin
                     grp_cnt_in[i] = (GC_W'(i) < groups_ff) ? bpg_eff : '0;
                  end
                  total_in = (CMP_W'(span_ff) > CMP_W'(TOTAL_CNT_MAX)) ?
                             BLK_W'(TOTAL_CNT_MAX) : BLK_W'(span_ff);
                  state_in = ST_DONE;
               end
               ACT_FREE, ACT_MARK: begin
                  if ((act_ff == ACT_FREE) && (blk_ff == '0)) begin
                     res_sts_in = STS_ZERO;
                     state_in   = ST_DONE;
                  end else if ((blk_ff < BLK_W'(fdb_ff)) ||
                               (CMP_W'(rel) >= CMP_W'(span_ff))) begin
                     res_sts_in = STS_RANGE;
                     state_in   = ST_DONE;
                  end else begin
                     state_in = ST_DIV;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_DIV: begin
            if (rem_ff >= BLK_W'(bpg_eff)) begin
               rem_in      = rem_ff - BLK_W'(bpg_eff);
               g_in        = g_ff + GC_W'(1);
               grp_base_in = grp_base_ff + GRP_STRIDE;
            end else begin
               w_in     = pos[POS_W-1:6];
               bit_in   = pos[5:0];
               state_in = ST_READ;
            end
         end
         ST_GSEL: begin
            if (g_ff >= groups_ff) begin
               res_sts_in = STS_NO_FREE;
               state_in   = ST_DONE;
            end else if (cnt_sel == '0) begin
               g_in        = g_ff + GC_W'(1);
               grp_base_in = grp_base_ff + GRP_STRIDE;
               grp_off_in  = grp_off_ff + SPAN_W'(bpg_eff);
            end else begin
               w_in     = grp_base_ff[POS_W-1:6];
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (act_ff == ACT_ALLOC) begin
               if (|free_vec) begin
                  mem_we                       = 1'b1;
                  mem_wdata                    = rd_data | (WORD_W'(1) << first_j);
                  grp_cnt_in[g_ff[GI_W-1:0]]   = cnt_sel - BPG_W'(cnt_sel != '0);
                  total_in                     = total_ff - BLK_W'(total_ff != '0);
                  res_blk_in                   = BLK_W'(alloc_sum);
                  state_in                     = ST_DONE;
               end else if (end_here) begin
                  g_in        = g_ff + GC_W'(1);
                  grp_base_in = grp_base_ff + GRP_STRIDE;
                  grp_off_in  = grp_off_ff + SPAN_W'(bpg_eff);
                  state_in    = ST_GSEL;
               end else begin
                  w_in     = w_ff + WA_W'(1);
                  state_in = ST_READ;
               end
            end else if (act_ff == ACT_FREE) begin
               mem_we    = 1'b1;
               mem_wdata = rd_data & ~(WORD_W'(1) << bit_ff);
               if (cnt_sel != BPG_W'(GROUP_CNT_MAX)) begin
                  grp_cnt_in[g_ff[GI_W-1:0]] = cnt_sel + BPG_W'(1);
               end
               if (total_ff != BLK_W'(TOTAL_CNT_MAX)) begin
                  total_in = total_ff + BLK_W'(1);
               end
               state_in = ST_DONE;
            end else begin
               if (!rd_data[bit_ff]) begin
                  mem_we                     = 1'b1;
                  mem_wdata                  = rd_data | (WORD_W'(1) << bit_ff);
                  grp_cnt_in[g_ff[GI_W-1:0]] = cnt_sel - BPG_W'(cnt_sel != '0);
                  total_in                   = total_ff - BLK_W'(total_ff != '0);
               end
               state_in = ST_DONE;
            end
            if (mem_we) begin
               word_vld_in[w_ff] = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_blk_in   = rsp_blk_ff;
      rsp_sts_in   = rsp_sts_ff;
      rsp_tot_in   = rsp_tot_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_in = 1'b1;
         rsp_blk_in   = res_blk_ff;
         rsp_sts_in   = res_sts_ff;
         rsp_tot_in   = total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[w_ff] <= mem_wdata;
      end
      rd_word_ff <= bitmap_mem[w_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bpg_ff       <= RST_BLOCKS_PER_GROUP;
         tblk_ff      <= RST_TOTAL_BLOCKS;
         fdb_ff       <= RST_FIRST_DATA_BLOCK;
         geo_busy_ff  <= 1'b1;
         groups_ff    <= '0;
         span_ff      <= '0;
         total_ff     <= '0;
         word_vld_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_GROUPS; i++) begin
            grp_cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         bpg_ff       <= bpg_in;
         tblk_ff      <= tblk_in;
         fdb_ff       <= fdb_in;
         geo_busy_ff  <= geo_busy_in;
         groups_ff    <= groups_in;
         span_ff      <= span_in;
         total_ff     <= total_in;
         word_vld_ff  <= word_vld_in;
         rd_vld_ff    <= word_vld_ff[w_ff];
         rsp_valid_ff <= rsp_valid_in;
         grp_cnt_ff   <= grp_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      blk_ff      <= blk_in;
      rem_ff      <= rem_in;
      g_ff        <= g_in;
      grp_base_ff <= grp_base_in;
      grp_off_ff  <= grp_off_in;
      w_ff        <= w_in;
      bit_ff      <= bit_in;
      res_blk_ff  <= res_blk_in;
      res_sts_ff  <= res_sts_in;
      rsp_blk_ff  <= rsp_blk_in;
      rsp_sts_ff  <= rsp_sts_in;
      rsp_tot_ff  <= rsp_tot_in;
   end

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_DECODE))
      else $error("accepted transfer did not enter decode");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

   a_div_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (g_ff < groups_ff))
      else $error("block mapping ran past the group count");

endmodule
